### rtl/gffp_pkg.sv
package gffp_pkg;

    localparam int MAX_COLUMNS = 16;
    localparam int MAX_ROWS    = 16;

    // width of the grid registers and of the span fields
    localparam int GRID_W  = 5;
    // width of a placed coordinate
    localparam int PLACE_W = 4;
    localparam int ROW_AW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = GRID_W;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 1'd1;

    localparam logic [GRID_W-1:0] GRID_RESET = 5'd16;

    localparam logic [1:0] STATUS_PLACED  = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_NO_ROOM = 2'd2;
    localparam logic [1:0] STATUS_FAILED  = 2'd3;

    typedef struct packed {
        logic               first_of_batch;
        logic [PLACE_W-1:0] want_column;
        logic               column_is_auto;
        logic [PLACE_W-1:0] want_row;
        logic               row_is_auto;
        logic [GRID_W-1:0]  span_columns;
        logic [GRID_W-1:0]  span_rows;
    } gffp_in_t;

    typedef struct packed {
        logic [PLACE_W-1:0] placed_column;
        logic [PLACE_W-1:0] placed_row;
        logic [1:0]         status;
    } gffp_out_t;

    // low span bits set, column 0 aligned
    function automatic logic [MAX_COLUMNS-1:0] span_mask(input logic [GRID_W-1:0] span);
        return ~({MAX_COLUMNS{1'b1}} << span);
    endfunction

endpackage

### rtl/gffp_ram.sv
module gffp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/gffp_col_fit.sv
module gffp_col_fit (
    input  logic [gffp_pkg::MAX_COLUMNS-1:0] occ,
    input  logic [gffp_pkg::GRID_W-1:0]      span,
    input  logic [gffp_pkg::GRID_W-1:0]      col_lo,
    input  logic [gffp_pkg::GRID_W-1:0]      col_hi,
    output logic                             found,
    output logic [gffp_pkg::PLACE_W-1:0]     col
);
    import gffp_pkg::*;

    logic [MAX_COLUMNS-1:0] base;
    logic [MAX_COLUMNS-1:0] hit;

    assign base = span_mask(span);

    always_comb begin
        for (int c = 0; c < MAX_COLUMNS; c++) begin
            hit[c] = (c >= int'(col_lo)) && (c < int'(col_hi)) &&
                     ((occ & (base << c)) == '0);
        end
    end

    // lowest free start column wins
    always_comb begin
        found = |hit;
        col   = '0;
        for (int c = MAX_COLUMNS - 1; c >= 0; c--) begin
            if (hit[c]) begin
                col = PLACE_W'(c);
            end
        end
    end

endmodule

### rtl/grid_first_fit_placer.sv
// Grid first-fit placer.
// Input words (s_valid/s_ready/s_data) each ask for a rectangle of span_columns
// by span_rows cells, at a fixed or automatic start column and row. Every word
// gives exactly one result word (m_valid/m_ready/m_data): placed column, row
// and a status (placed, invalid item, no free area, batch already failed).
// grid_columns and grid_rows are written through cfg_we/cfg_index/cfg_wdata,
// by the user only while the block is idle, which the block does not enforce; both reset to 16.
// The occupancy map is one word per grid row in a RAM with one read and one
// write port; a row bit vector marks which words hold data since the last
// clear, so first_of_batch clears the whole map in the accept cycle.
// Sequence after accept: a failed or invalid item goes straight to the done
// state; an item with both coordinates fixed marks its rows; a searched item
// tries candidate rows in turn and then marks the area it found. Each candidate
// row reads S words through the RAM read port, and marking rewrites S words,
// where S is span_rows.
// The next word is taken as soon as the result sits in the output register.
// If the receiver stalls, the result is held there; a second result waits in
// the sequencer, and s_ready stays low until the output register frees up.
// Reset (aresetn, synchronous) empties the map, clears the failure flag and
// drops m_valid.
module grid_first_fit_placer (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  gffp_pkg::gffp_in_t                   s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output gffp_pkg::gffp_out_t                  m_data,
    input  logic                                 cfg_we,
    input  logic [gffp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gffp_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import gffp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEARCH = 4'b0010,
        ST_MARK   = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [GRID_W-1:0]      grid_cols_reg, grid_cols_next;
    logic [GRID_W-1:0]      grid_rows_reg, grid_rows_next;
    logic                   batch_failed_reg, batch_failed_next;
    logic [MAX_ROWS-1:0]    row_valid_reg, row_valid_next;
    logic [GRID_W-1:0]      sc_reg, sc_next;
    logic [GRID_W-1:0]      col_lo_reg, col_lo_next;
    logic [GRID_W-1:0]      col_hi_reg, col_hi_next;
    logic [GRID_W-1:0]      row_hi_reg, row_hi_next;
    logic [GRID_W-1:0]      r_reg, r_next;
    logic [GRID_W-1:0]      y_reg, y_next;
    logic [GRID_W-1:0]      end_reg, end_next;
    logic                   rd_pend_reg, rd_pend_next;
    logic                   rd_valid_reg, rd_valid_next;
    logic [ROW_AW-1:0]      rd_addr_reg, rd_addr_next;
    logic [MAX_COLUMNS-1:0] acc_reg, acc_next;
    logic [MAX_COLUMNS-1:0] mask_reg, mask_next;
    logic [PLACE_W-1:0]     pc_reg, pc_next;
    logic [PLACE_W-1:0]     pr_reg, pr_next;
    logic [1:0]             status_reg, status_next;
    logic                   m_valid_reg, m_valid_next;
    gffp_out_t              m_data_reg, m_data_next;

    logic                   ram_we;
    logic [ROW_AW-1:0]      ram_waddr;
    logic [MAX_COLUMNS-1:0] ram_wdata;
    logic [ROW_AW-1:0]      ram_raddr;
    logic [MAX_COLUMNS-1:0] ram_rdata;
    logic [MAX_COLUMNS-1:0] rdata_eff;
    logic [MAX_COLUMNS-1:0] acc_cur;

    logic                   fit_found;
    logic [PLACE_W-1:0]     fit_col;

    logic [GRID_W-1:0]      cols, rows;
    logic                   accept;
    logic                   failed_eff;
    logic                   invalid;
    logic                   issue;
    logic [GRID_W:0]        wc_ext, wr_ext;
    logic [GRID_W-1:0]      r_inc;

    gffp_ram #(
        .WIDTH (MAX_COLUMNS),
        .DEPTH (MAX_ROWS)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    gffp_col_fit u_fit (
        .occ    (acc_cur),
        .span   (sc_reg),
        .col_lo (col_lo_reg),
        .col_hi (col_hi_reg),
        .found  (fit_found),
        .col    (fit_col)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign cols = (int'(grid_cols_reg) > MAX_COLUMNS) ? GRID_W'(MAX_COLUMNS) : grid_cols_reg;
    assign rows = (int'(grid_rows_reg) > MAX_ROWS) ? GRID_W'(MAX_ROWS) : grid_rows_reg;

    assign wc_ext = (GRID_W + 1)'(s_data.want_column);
    assign wr_ext = (GRID_W + 1)'(s_data.want_row);

    assign failed_eff = !s_data.first_of_batch && batch_failed_reg;

    assign invalid =
        (s_data.span_columns == '0) || (s_data.span_rows == '0) ||
        (s_data.span_columns > cols) || (s_data.span_rows > rows) ||
        (!s_data.column_is_auto &&
         ((wc_ext >= {1'b0, cols}) ||
          ({1'b0, s_data.span_columns} > ({1'b0, cols} - wc_ext)))) ||
        (!s_data.row_is_auto &&
         ((wr_ext >= {1'b0, rows}) ||
          ({1'b0, s_data.span_rows} > ({1'b0, rows} - wr_ext))));

    // a row never written since the last clear reads as empty
    assign rdata_eff = rd_valid_reg ? ram_rdata : '0;
    assign acc_cur   = acc_reg | (rd_pend_reg ? rdata_eff : '0);
    assign issue     = (y_reg != end_reg);
    assign r_inc     = r_reg + GRID_W'(1);

    always_comb begin
        state_next        = state_reg;
        grid_cols_next    = grid_cols_reg;
        grid_rows_next    = grid_rows_reg;
        batch_failed_next = batch_failed_reg;
        row_valid_next    = row_valid_reg;
        sc_next           = sc_reg;
        col_lo_next       = col_lo_reg;
        col_hi_next       = col_hi_reg;
        row_hi_next       = row_hi_reg;
        r_next            = r_reg;
        y_next            = y_reg;
        end_next          = end_reg;
        rd_pend_next      = 1'b0;
        rd_valid_next     = rd_valid_reg;
        rd_addr_next      = rd_addr_reg;
        acc_next          = acc_reg;
        mask_next         = mask_reg;
        pc_next           = pc_reg;
        pr_next           = pr_reg;
        status_next       = status_reg;
        m_valid_next      = m_valid_reg;
        m_data_next       = m_data_reg;
        ram_we            = 1'b0;
        ram_waddr         = rd_addr_reg;
        ram_wdata         = rdata_eff | mask_reg;
        ram_raddr         = ROW_AW'(y_reg);

        if (cfg_we) begin
            case (cfg_index)
                REG_GRID_COLUMNS: grid_cols_next = cfg_wdata;
                REG_GRID_ROWS:    grid_rows_next = cfg_wdata;
                default: ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.first_of_batch) begin
                        row_valid_next    = '0;
                        batch_failed_next = 1'b0;
                    end
                    sc_next     = s_data.span_columns;
                    pc_next     = '0;
                    pr_next     = '0;
                    acc_next    = '0;
                    status_next = STATUS_PLACED;
                    if (failed_eff) begin
                        status_next = STATUS_FAILED;
                        state_next  = ST_DONE;
                    end else if (invalid) begin
                        status_next       = STATUS_INVALID;
                        batch_failed_next = 1'b1;
                        state_next        = ST_DONE;
                    end else if (!s_data.column_is_auto && !s_data.row_is_auto) begin
                        pc_next    = s_data.want_column;
                        pr_next    = s_data.want_row;
                        mask_next  = span_mask(s_data.span_columns) << s_data.want_column;
                        y_next     = GRID_W'(s_data.want_row);
                        end_next   = GRID_W'(s_data.want_row) + s_data.span_rows;
                        state_next = ST_MARK;
                    end else begin
                        col_lo_next = s_data.column_is_auto ? '0 : GRID_W'(s_data.want_column);
                        col_hi_next = s_data.column_is_auto ?
                                      cols - s_data.span_columns + GRID_W'(1) :
                                      GRID_W'(s_data.want_column) + GRID_W'(1);
                        r_next      = s_data.row_is_auto ? '0 : GRID_W'(s_data.want_row);
                        row_hi_next = s_data.row_is_auto ?
                                      rows - s_data.span_rows + GRID_W'(1) :
                                      GRID_W'(s_data.want_row) + GRID_W'(1);
                        y_next      = s_data.row_is_auto ? '0 : GRID_W'(s_data.want_row);
                        end_next    = (s_data.row_is_auto ? '0 : GRID_W'(s_data.want_row)) +
                                      s_data.span_rows;
                        state_next  = ST_SEARCH;
                    end
                end
            end

            ST_SEARCH: begin
                // OR the span rows under the candidate row, one word a cycle
                acc_next = acc_cur;
                if (issue) begin
                    rd_pend_next  = 1'b1;
                    rd_valid_next = row_valid_reg[ROW_AW'(y_reg)];
                    rd_addr_next  = ROW_AW'(y_reg);
                    y_next        = y_reg + GRID_W'(1);
                end else if (fit_found) begin
                    pc_next    = fit_col;
                    pr_next    = PLACE_W'(r_reg);
                    mask_next  = span_mask(sc_reg) << fit_col;
                    y_next     = r_reg;
                    state_next = ST_MARK;
                end else if (r_inc >= row_hi_reg) begin
                    status_next       = STATUS_NO_ROOM;
                    batch_failed_next = 1'b1;
                    state_next        = ST_DONE;
                end else begin
                    // advance to the next candidate row
                    r_next   = r_inc;
                    y_next   = r_inc;
                    end_next = end_reg + GRID_W'(1);
                    acc_next = '0;
                end
            end

            ST_MARK: begin
                // write back row y-1 while reading row y: never the same entry
                if (rd_pend_reg) begin
                    ram_we                      = 1'b1;
                    row_valid_next[rd_addr_reg] = 1'b1;
                end
                if (issue) begin
                    rd_pend_next  = 1'b1;
                    rd_valid_next = row_valid_reg[ROW_AW'(y_reg)];
                    rd_addr_next  = ROW_AW'(y_reg);
                    y_next        = y_reg + GRID_W'(1);
                end else begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_data_next.placed_column = pc_reg;
                    m_data_next.placed_row    = pr_reg;
                    m_data_next.status        = status_reg;
                    state_next                = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            grid_cols_reg    <= GRID_RESET;
            grid_rows_reg    <= GRID_RESET;
            batch_failed_reg <= 1'b0;
            row_valid_reg    <= '0;
            rd_pend_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            grid_cols_reg    <= grid_cols_next;
            grid_rows_reg    <= grid_rows_next;
            batch_failed_reg <= batch_failed_next;
            row_valid_reg    <= row_valid_next;
            rd_pend_reg      <= rd_pend_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sc_reg       <= sc_next;
        col_lo_reg   <= col_lo_next;
        col_hi_reg   <= col_hi_next;
        row_hi_reg   <= row_hi_next;
        r_reg        <= r_next;
        y_reg        <= y_next;
        end_reg      <= end_next;
        rd_valid_reg <= rd_valid_next;
        rd_addr_reg  <= rd_addr_next;
        acc_reg      <= acc_next;
        mask_reg     <= mask_next;
        pc_reg       <= pc_next;
        pr_reg       <= pr_next;
        status_reg   <= status_next;
        m_data_reg   <= m_data_next;
    end

endmodule

### tb/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gffp_pkg::*;

    localparam int CYCLE_LIMIT     = 3_000_000;
    localparam int PHASES          = 16;
    localparam int WORDS_PER_PHASE = 100;

    // Tracks occupancy and failure state of the grid and queues the expected placements.
    class placement_board;
        logic [MAX_COLUMNS-1:0] occupied [MAX_ROWS];
        bit                     failed;
        logic [GRID_W-1:0]      grid_cols;
        logic [GRID_W-1:0]      grid_rows;
        gffp_out_t              awaited [$];
        int                     mismatches;

        function new();
            foreach (occupied[y]) occupied[y] = '0;
            failed     = 1'b0;
            grid_cols  = GRID_RESET;
            grid_rows  = GRID_RESET;
            mismatches = 0;
        endfunction

        function void set_grid(logic [CFG_IDX_W-1:0] idx, logic [GRID_W-1:0] value);
            if (idx == REG_GRID_COLUMNS) grid_cols = value;
            else if (idx == REG_GRID_ROWS) grid_rows = value;
        endfunction

        function int eff_cols();
            return (grid_cols > MAX_COLUMNS) ? MAX_COLUMNS : int'(grid_cols);
        endfunction

        function int eff_rows();
            return (grid_rows > MAX_ROWS) ? MAX_ROWS : int'(grid_rows);
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function logic [31:0] cell_mask(int c, int sc);
            return ((32'd1 << sc) - 32'd1) << c;
        endfunction

        function bit area_free(int c, int r, int sc, int sr);
            logic [31:0] m;
            m = cell_mask(c, sc);
            for (int y = r; y < r + sr && y < MAX_ROWS; y++)
                if ((32'(occupied[y]) & m) != 0) return 1'b0;
            return 1'b1;
        endfunction

        function void mark(int c, int r, int sc, int sr);
            logic [31:0] m;
            m = cell_mask(c, sc);
            for (int y = r; y < r + sr && y < MAX_ROWS; y++)
                occupied[y] |= m[MAX_COLUMNS-1:0];
        endfunction

        function gffp_out_t place(gffp_in_t d);
            int        cols, rows, sc, sr, wc, wr, cb, ce, rb, re, r, c;
            bit        found;
            gffp_out_t res;
            cols  = eff_cols();
            rows  = eff_rows();
            sc    = int'(d.span_columns);
            sr    = int'(d.span_rows);
            wc    = int'(d.want_column);
            wr    = int'(d.want_row);
            res   = '0;
            res.status = STATUS_PLACED;
            found = 1'b0;
            if (d.first_of_batch) begin
                foreach (occupied[y]) occupied[y] = '0;
                failed = 1'b0;
            end
            if (failed) begin
                res.status = STATUS_FAILED;
            end else if (sc == 0 || sr == 0 || sc > cols || sr > rows ||
                         (!d.column_is_auto && (wc >= cols || sc > cols - wc)) ||
                         (!d.row_is_auto && (wr >= rows || sr > rows - wr))) begin
                res.status = STATUS_INVALID;
                failed     = 1'b1;
            end else if (!d.column_is_auto && !d.row_is_auto) begin
                // both fixed: mark without an overlap check
                mark(wc, wr, sc, sr);
                res.placed_column = wc[PLACE_W-1:0];
                res.placed_row    = wr[PLACE_W-1:0];
            end else begin
                cb = d.column_is_auto ? 0 : wc;
                ce = d.column_is_auto ? cols - sc + 1 : wc + 1;
                rb = d.row_is_auto ? 0 : wr;
                re = d.row_is_auto ? rows - sr + 1 : wr + 1;
                for (r = rb; r < re && !found; r++) begin
                    for (c = cb; c < ce && !found; c++) begin
                        if (area_free(c, r, sc, sr)) begin
                            found = 1'b1;
                            res.placed_column = c[PLACE_W-1:0];
                            res.placed_row    = r[PLACE_W-1:0];
                        end
                    end
                end
                if (found) begin
                    mark(int'(res.placed_column), int'(res.placed_row), sc, sr);
                end else begin
                    res.status = STATUS_NO_ROOM;
                    failed     = 1'b1;
                end
            end
            return res;
        endfunction

        function void note_word(gffp_in_t d);
            awaited.push_back(place(d));
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_word(gffp_out_t got);
            gffp_out_t want;
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("unexpected result word %h", got));
            end else begin
                want = awaited.pop_front();
                if (got.placed_column !== want.placed_column)
                    report_mismatch($sformatf("placed_column %0d, want %0d",
                                              got.placed_column, want.placed_column));
                if (got.placed_row !== want.placed_row)
                    report_mismatch($sformatf("placed_row %0d, want %0d",
                                              got.placed_row, want.placed_row));
                if (got.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              got.status, want.status));
            end
        endtask
    endclass

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    gffp_in_t                s_data;
    logic                    m_valid;
    logic                    m_ready;
    gffp_out_t               m_data;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_wdata;

    placement_board board;
    int             send_idle_pct;
    int             recv_stall_pct;
    int             cycle_count;

    grid_first_fit_placer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
    end

    always #2 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_word(m_data);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic gffp_in_t word_of(bit first, int wc, bit cauto, int wr, bit rauto,
                                         int sc, int sr);
        gffp_in_t d;
        d.first_of_batch = first;
        d.want_column    = wc[PLACE_W-1:0];
        d.column_is_auto = cauto;
        d.want_row       = wr[PLACE_W-1:0];
        d.row_is_auto    = rauto;
        d.span_columns   = sc[GRID_W-1:0];
        d.span_rows      = sr[GRID_W-1:0];
        return d;
    endfunction

    // Mostly well-formed batches sized to the current grid, some raw noise.
    function automatic gffp_in_t random_word();
        logic [$bits(gffp_in_t)-1:0] raw;
        gffp_in_t d;
        int gc, gr, sc, sr;
        raw = $bits(gffp_in_t)'($urandom);
        d   = raw;
        if ($urandom_range(99) < 8) return d;
        gc = (board.eff_cols() == 0) ? 1 : board.eff_cols();
        gr = (board.eff_rows() == 0) ? 1 : board.eff_rows();
        sc = ($urandom_range(99) < 70) ? $urandom_range(1, (gc < 4) ? gc : 4)
                                       : $urandom_range(1, gc);
        sr = ($urandom_range(99) < 70) ? $urandom_range(1, (gr < 4) ? gr : 4)
                                       : $urandom_range(1, gr);
        d.first_of_batch = board.failed ? ($urandom_range(99) < 85)
                                        : ($urandom_range(99) < 6);
        d.column_is_auto = ($urandom_range(99) < 60);
        d.row_is_auto    = ($urandom_range(99) < 60);
        if (!d.column_is_auto) d.want_column = PLACE_W'($urandom_range(0, gc - sc));
        if (!d.row_is_auto) d.want_row = PLACE_W'($urandom_range(0, gr - sr));
        d.span_columns = GRID_W'(sc);
        d.span_rows    = GRID_W'(sr);
        return d;
    endfunction

    // Enter and leave at a falling edge; valid stays high after the accept.
    task send_word(gffp_in_t d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            s_data  <= $bits(gffp_in_t)'($urandom);
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        do @(posedge aclk); while (!s_ready);
        board.note_word(d);
        @(negedge aclk);
    endtask

    // Drop valid and hold until every result word has come back.
    task settle(int extra);
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
        @(negedge aclk);
    endtask

    task write_grid(logic [CFG_IDX_W-1:0] idx, int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CFG_DATA_W-1:0];
        board.set_grid(idx, value[GRID_W-1:0]);
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task set_idling(int mode);
        case (mode)
            0: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1: begin
                send_idle_pct  = 55;
                recv_stall_pct = 0;
            end
            2: begin
                send_idle_pct  = 0;
                recv_stall_pct = 55;
            end
            default: begin
                send_idle_pct  = 23;
                recv_stall_pct = 23;
            end
        endcase
    endtask

    initial begin
        int phase_cols [PHASES];
        int phase_rows [PHASES];
        phase_cols = '{16, 1, 4, 16, 1, 8, 0, 12, 31, 5, 16, 3, 17, 10, 2, 16};
        phase_rows = '{16, 1, 7, 1, 16, 8, 5, 0, 20, 9, 16, 16, 3, 31, 2, 12};
        board       = new();
        cycle_count = 0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        m_ready     = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_GRID_COLUMNS;
        cfg_wdata   = '0;
        set_idling(0);
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // full grid, then auto search on a full map
        send_word(word_of(1, 0, 0, 0, 0, 16, 16));
        send_word(word_of(0, 0, 1, 0, 1, 1, 1));
        send_word(word_of(0, 0, 1, 0, 1, 1, 1));
        // zero and oversized spans
        send_word(word_of(1, 0, 1, 0, 1, 0, 3));
        send_word(word_of(0, 0, 1, 0, 1, 1, 1));
        send_word(word_of(1, 0, 1, 0, 1, 2, 0));
        send_word(word_of(1, 0, 1, 0, 1, 31, 31));
        // fixed start that runs off the grid edge
        send_word(word_of(1, 15, 0, 0, 1, 2, 1));
        send_word(word_of(1, 0, 1, 15, 0, 1, 2));
        send_word(word_of(1, 15, 0, 15, 0, 1, 1));
        send_word(word_of(0, 0, 1, 0, 1, 1, 1));
        send_word(word_of(0, 0, 1, 0, 1, 3, 2));
        send_word(word_of(0, 2, 0, 0, 1, 2, 2));
        send_word(word_of(0, 0, 1, 5, 0, 16, 1));
        send_word(word_of(0, 0, 1, 5, 0, 1, 1));
        // overlapping fixed areas are both placed
        send_word(word_of(1, 0, 0, 0, 0, 4, 4));
        send_word(word_of(0, 2, 0, 2, 0, 4, 4));
        send_word(word_of(0, 0, 1, 0, 1, 16, 16));
        send_word(word_of(1, 0, 1, 0, 1, 16, 16));
        send_word(word_of(1, 15, 1, 15, 1, 16, 1));
        send_word(word_of(0, 0, 1, 0, 1, 16, 15));
        send_word(word_of(0, 0, 1, 0, 1, 16, 1));

        for (int p = 0; p < PHASES; p++) begin
            settle(4);
            write_grid(REG_GRID_COLUMNS, phase_cols[p]);
            write_grid(REG_GRID_ROWS, phase_rows[p]);
            set_idling(p % 4);
            repeat (WORDS_PER_PHASE) begin
                if ($urandom_range(59) == 0) settle(0);
                send_word(random_word());
            end
        end

        settle(20);
        if (board.mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
